>>> rtl/core/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, codes and constants of the battery health checker.
// ----------------------------------------------------------------------------
package bhc_pkg;

  localparam int VOLT_W   = 16;
  localparam int CURR_W   = 16;
  localparam int TS_W     = 48;
  localparam int RATE_W   = 27;
  localparam int NUM_W    = 26;
  localparam int DROP_W   = 26;
  localparam int IMAX_W   = 15;
  localparam int COUNT_W  = 32;
  localparam int FLAGS_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Millivolts per second from millivolts per millisecond.
  localparam int RATE_SCALE = 1000;

  localparam logic [VOLT_W-1:0] CRITICAL_RST  = 16'd6000;
  localparam logic [VOLT_W-1:0] AOCS_OFF_RST  = 16'd6600;
  localparam logic [VOLT_W-1:0] MAX_VOLT_RST  = 16'd8400;
  localparam logic [DROP_W-1:0] MAX_DROP_RST  = 26'd1000;
  localparam logic [IMAX_W-1:0] MAX_CURR_RST  = 15'd2000;
  localparam logic [15:0]       PERIOD_RST    = 16'd100;

  // Fault mask bit positions.
  localparam int FLAG_TIMESTAMP = 0;
  localparam int FLAG_CRITICAL  = 1;
  localparam int FLAG_LOW       = 2;
  localparam int FLAG_OVERVOLT  = 3;
  localparam int FLAG_DROP      = 4;
  localparam int FLAG_OVERCURR  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRITICAL = 3'd0,
    REG_AOCS_OFF = 3'd1,
    REG_MAX_VOLT = 3'd2,
    REG_MAX_DROP = 3'd3,
    REG_MAX_CURR = 3'd4,
    REG_PERIOD   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CFG = 2'd1,
    STATUS_STALE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEV_OK       = 2'd0,
    SEV_WARNING  = 2'd1,
    SEV_ERROR    = 2'd2,
    SEV_CRITICAL = 2'd3
  } severity_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [VOLT_W-1:0] critical_mv;
    logic [VOLT_W-1:0] aocs_off_mv;
    logic [VOLT_W-1:0] max_voltage_mv;
    logic [DROP_W-1:0] max_drop_rate_mv_s;
    logic [IMAX_W-1:0] max_current_ma;
    logic              ok;
  } cfg_t;

endpackage

>>> rtl/core/bhc_sample_if.sv
// ----------------------------------------------------------------------------
// bhc_sample_if
// Valid/ready channel carrying one battery sample word.
// ----------------------------------------------------------------------------
interface bhc_sample_if import bhc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VOLT_W-1:0]        voltage_mv;
  logic signed [CURR_W-1:0] current_ma;
  logic [TS_W-1:0]          stamp_ms;

  modport source (output valid, voltage_mv, current_ma, stamp_ms, input ready);
  modport sink   (input valid, voltage_mv, current_ma, stamp_ms, output ready);
endinterface

>>> rtl/core/bhc_result_if.sv
// ----------------------------------------------------------------------------
// bhc_result_if
// Valid/ready channel carrying one health check result word.
// ----------------------------------------------------------------------------
interface bhc_result_if import bhc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [FLAGS_W-1:0]       fault_flags;
  logic [1:0]               severity;
  logic                     aocs_off_request;
  logic signed [RATE_W-1:0] rate_mv_per_s;
  logic                     rate_known;
  logic [COUNT_W-1:0]       samples_seen;

  modport source (output valid, status, fault_flags, severity, aocs_off_request,
                  rate_mv_per_s, rate_known, samples_seen, input ready);
  modport sink   (input valid, status, fault_flags, severity, aocs_off_request,
                  rate_mv_per_s, rate_known, samples_seen, output ready);
endinterface

>>> rtl/core/bhc_config.sv
// ----------------------------------------------------------------------------
// bhc_config
// Threshold registers with write port and configuration validity check.
// ----------------------------------------------------------------------------
module bhc_config import bhc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  logic [VOLT_W-1:0] critical_mv;
  logic [VOLT_W-1:0] aocs_off_mv;
  logic [VOLT_W-1:0] max_voltage_mv;
  logic [DROP_W-1:0] max_drop_rate_mv_s;
  logic [IMAX_W-1:0] max_current_ma;
  logic [15:0]       sample_period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      critical_mv        <= CRITICAL_RST;
      aocs_off_mv        <= AOCS_OFF_RST;
      max_voltage_mv     <= MAX_VOLT_RST;
      max_drop_rate_mv_s <= MAX_DROP_RST;
      max_current_ma     <= MAX_CURR_RST;
      sample_period_ms   <= PERIOD_RST;
    end else if (wr_en) begin
      case (index)
        REG_CRITICAL: critical_mv        <= data[VOLT_W-1:0];
        REG_AOCS_OFF: aocs_off_mv        <= data[VOLT_W-1:0];
        REG_MAX_VOLT: max_voltage_mv     <= data[VOLT_W-1:0];
        REG_MAX_DROP: max_drop_rate_mv_s <= data[DROP_W-1:0];
        REG_MAX_CURR: max_current_ma     <= data[IMAX_W-1:0];
        REG_PERIOD:   sample_period_ms   <= data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.critical_mv        = critical_mv;
    cfg.aocs_off_mv        = aocs_off_mv;
    cfg.max_voltage_mv     = max_voltage_mv;
    cfg.max_drop_rate_mv_s = max_drop_rate_mv_s;
    cfg.max_current_ma     = max_current_ma;
    cfg.ok = (critical_mv != '0) && (critical_mv < aocs_off_mv) &&
             (aocs_off_mv < max_voltage_mv) && (max_drop_rate_mv_s != '0) &&
             (max_current_ma != '0) && (sample_period_ms != '0);
  end

endmodule

>>> rtl/core/bhc_divider.sv
// ----------------------------------------------------------------------------
// bhc_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bhc_divider import bhc_pkg::*; #(
  parameter int NUM_BITS = NUM_W,
  parameter int DEN_BITS = TS_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient,
  output logic                rem_nonzero
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] dq;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CNT_W-1:0]    cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    trial = {rem, dq[NUM_BITS-1]};
    fits  = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      dq  <= {dq[NUM_BITS-2:0], fits};
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign quotient    = dq;
  assign rem_nonzero = |rem;

endmodule

>>> rtl/core/battery_health_check_top.sv
// ----------------------------------------------------------------------------
// battery_health_check_top
// Battery voltage/current fault monitor with serial voltage rate divider.
//
//   Channel  Kind             Width  Contents
//   sample   valid/ready in   80     voltage_mv, current_ma, stamp_ms
//   result   valid/ready out  71     status, fault_flags, severity, aocs,
//                                    rate_mv_per_s, rate_known, samples_seen
//   cfg      write only       3+26   cfg_wr_en, cfg_index, cfg_data
//
// A word that needs a rate passes from the idle state, in which it is taken,
// through the prepare state, the bit-serial divider (26 quotient bits and its
// done pulse) and the output load before the next word can be accepted.
// Words without a rate skip the divider. The load waits for a free output.
// Reset is synchronous and restores the default thresholds and clears state.
// A new sample is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module battery_health_check_top import bhc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bhc_sample_if.sink            sample,
  bhc_result_if.source          result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  ctrl_state_t state, state_next;

  logic [VOLT_W-1:0]        v_q;
  logic signed [CURR_W-1:0] c_q;
  logic [TS_W-1:0]          ts_q;

  logic               has_prev;
  logic [VOLT_W-1:0]  prev_v;
  logic [TS_W-1:0]    prev_time;
  logic [COUNT_W-1:0] accepted_count;

  status_t            st_status;
  logic [FLAGS_W-1:0] base_flags;
  severity_t          base_sev;
  logic               base_aocs;
  logic               use_rate;
  logic               fall_q;

  logic [TS_W-1:0]    dt;
  logic               stale;
  logic               falling;
  logic [VOLT_W-1:0]  dv;
  logic [NUM_W-1:0]   num;
  logic [CURR_W-1:0]  cmag;
  logic               accept_ok;
  logic               div_start;

  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic               div_rnz;

  logic [FLAGS_W-1:0]       cls_flags;
  severity_t                cls_sev;
  logic                     cls_aocs;
  logic                     drop;
  severity_t                fin_sev;
  logic [RATE_W-1:0]        fin_rate;
  logic                     load;
  logic                     res_valid;

  bhc_config u_config (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  bhc_divider #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (TS_W)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (num),
    .divisor     (dt),
    .busy        (div_busy),
    .done        (div_done),
    .quotient    (div_quot),
    .rem_nonzero (div_rnz)
  );

  assign sample.ready = (state == ST_IDLE) && !rst;

  // Checks of the captured sample, evaluated in the prepare cycle.
  always_comb begin
    dt        = ts_q - prev_time;
    stale     = has_prev && (ts_q <= prev_time);
    falling   = v_q < prev_v;
    dv        = falling ? (prev_v - v_q) : (v_q - prev_v);
    num       = NUM_W'(dv) * NUM_W'(RATE_SCALE);
    cmag      = c_q[CURR_W-1] ? CURR_W'(-c_q) : CURR_W'(c_q);
    accept_ok = cfg.ok && !stale;
    div_start = (state == ST_PREP) && accept_ok && has_prev;

    cls_flags = '0;
    cls_sev   = SEV_OK;
    cls_aocs  = 1'b0;
    if (v_q <= cfg.critical_mv) begin
      cls_flags[FLAG_CRITICAL] = 1'b1;
      cls_sev  = SEV_CRITICAL;
      cls_aocs = 1'b1;
    end else if (v_q < cfg.aocs_off_mv) begin
      cls_flags[FLAG_LOW] = 1'b1;
      cls_sev  = SEV_ERROR;
      cls_aocs = 1'b1;
    end else if (v_q >= cfg.max_voltage_mv) begin
      cls_flags[FLAG_OVERVOLT] = 1'b1;
      cls_sev = SEV_ERROR;
    end
    if (cmag >= {1'b0, cfg.max_current_ma}) begin
      cls_flags[FLAG_OVERCURR] = 1'b1;
      cls_aocs = 1'b1;
      if (cls_sev == SEV_OK) begin
        cls_sev = SEV_ERROR;
      end
    end
  end

  // Drop rate: the exact fall rate exceeds the limit when the quotient is
  // above it, or equal to it with a nonzero remainder.
  always_comb begin
    drop = use_rate && fall_q &&
           ((div_quot > cfg.max_drop_rate_mv_s) ||
            ((div_quot == cfg.max_drop_rate_mv_s) && div_rnz));
    fin_sev = base_sev;
    if (drop && (base_sev == SEV_OK)) begin
      fin_sev = SEV_WARNING;
    end
    if (!use_rate) begin
      fin_rate = '0;
    end else if (fall_q) begin
      fin_rate = RATE_W'(-{1'b0, div_quot});
    end else begin
      fin_rate = RATE_W'({1'b0, div_quot});
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || result.ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      has_prev       <= 1'b0;
      prev_v         <= '0;
      prev_time      <= '0;
      accepted_count <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_PREP) && accept_ok) begin
        has_prev  <= 1'b1;
        prev_v    <= v_q;
        prev_time <= ts_q;
        if (accepted_count != '1) begin
          accepted_count <= accepted_count + 1'b1;
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      v_q  <= sample.voltage_mv;
      c_q  <= sample.current_ma;
      ts_q <= sample.stamp_ms;
    end
    if (state == ST_PREP) begin
      use_rate <= div_start;
      fall_q   <= falling;
      if (!cfg.ok) begin
        st_status  <= STATUS_BAD_CFG;
        base_flags <= '0;
        base_sev   <= SEV_OK;
        base_aocs  <= 1'b0;
      end else if (stale) begin
        st_status  <= STATUS_STALE;
        base_flags <= FLAGS_W'(1) << FLAG_TIMESTAMP;
        base_sev   <= SEV_ERROR;
        base_aocs  <= 1'b0;
      end else begin
        st_status  <= STATUS_OK;
        base_flags <= cls_flags;
        base_sev   <= cls_sev;
        base_aocs  <= cls_aocs;
      end
    end
    if (load) begin
      result.status           <= st_status;
      result.fault_flags      <= base_flags | (FLAGS_W'(drop) << FLAG_DROP);
      result.severity         <= fin_sev;
      result.aocs_off_request <= base_aocs;
      result.rate_mv_per_s    <= fin_rate;
      result.rate_known       <= use_rate;
      result.samples_seen     <= (st_status == STATUS_BAD_CFG) ? '0 : accepted_count;
    end
  end

  assign result.valid = res_valid;

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    ##1 accepted_count >= $past(accepted_count))
    else $error("sample count went backward");

  a_rate_only_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.rate_known |-> result.status == STATUS_OK)
    else $error("rate reported on a rejected sample");

  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.rate_known |-> result.rate_mv_per_s == '0)
    else $error("nonzero rate without rate_known");

endmodule
